[src/c6502_pkg.sv]
// Shared types, constants and decode helpers of the 6502 instruction core.
package c6502_pkg;

  localparam int MEM_DEPTH_DEF = 65536;

  localparam logic [15:0] RST_VEC_LO = 16'hFFFC;
  localparam logic [15:0] RST_VEC_HI = 16'hFFFD;
  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  P_RESET    = 8'h24;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] OP_PHP     = 8'h08;
  localparam logic [7:0] OP_CLC     = 8'h18;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_PLP     = 8'h28;
  localparam logic [7:0] OP_SEC     = 8'h38;
  localparam logic [7:0] OP_RTI     = 8'h40;
  localparam logic [7:0] OP_PHA     = 8'h48;
  localparam logic [7:0] OP_JMP     = 8'h4C;
  localparam logic [7:0] OP_CLI     = 8'h58;
  localparam logic [7:0] OP_RTS     = 8'h60;
  localparam logic [7:0] OP_PLA     = 8'h68;
  localparam logic [7:0] OP_JMP_IND = 8'h6C;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_DEY     = 8'h88;
  localparam logic [7:0] OP_STA_IMM = 8'h89;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_TYA     = 8'h98;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_TAY     = 8'hA8;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_CLV     = 8'hB8;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_SED     = 8'hF8;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_EXEC  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OPC_NORMAL,
    OPC_JSR,
    OPC_PULL
  } opclass_e;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_CLEAR,
    UOP_ACCEPT,
    UOP_MWRITE,
    UOP_MRD_ISSUE,
    UOP_MRD_LATCH,
    UOP_RST_LO,
    UOP_RST_HI,
    UOP_RST_END,
    UOP_F_OP,
    UOP_F_B1,
    UOP_F_B2,
    UOP_F_B2L,
    UOP_P_LO,
    UOP_P_HI,
    UOP_P_END,
    UOP_M_ISSUE,
    UOP_M_LATCH,
    UOP_EXEC,
    UOP_PUSH_LO,
    UOP_PULL_ISSUE,
    UOP_PULL_LATCH,
    UOP_STK_END,
    UOP_DONE
  } uop_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MWRITE,
    ST_MRD_ISSUE,
    ST_MRD_LATCH,
    ST_RST_LO,
    ST_RST_HI,
    ST_RST_END,
    ST_F_OP,
    ST_F_B1,
    ST_F_B2,
    ST_F_B2L,
    ST_P_LO,
    ST_P_HI,
    ST_P_END,
    ST_M_ISSUE,
    ST_M_LATCH,
    ST_EXEC,
    ST_PUSH_LO,
    ST_PULL_ISSUE,
    ST_PULL_LATCH,
    ST_STK_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    uop_e uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic     clear_done;
    logic     need_ptr;
    opclass_e opc;
    logic     pull_last;
  } dp_status_t;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FLAG_N] = v[7];
    r[FLAG_Z] = (v == 8'h00);
    return r;
  endfunction

  function automatic opclass_e op_class(input logic [7:0] op);
    opclass_e c;
    c = OPC_NORMAL;
    if (op == OP_JSR) begin
      c = OPC_JSR;
    end else if (op == OP_PLA || op == OP_PLP || op == OP_RTS || op == OP_RTI) begin
      c = OPC_PULL;
    end
    return c;
  endfunction

  function automatic logic [1:0] pull_count(input logic [7:0] op);
    logic [1:0] n;
    n = 2'd1;
    if (op == OP_RTS) begin
      n = 2'd2;
    end else if (op == OP_RTI) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

[src/c6502_ram.sv]
// Generic single-port RAM with registered read data.
module c6502_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/c6502_datapath.sv]
// Datapath of the 6502 core: registers, address generation, ALU and memory port muxing.
module c6502_datapath import c6502_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_cmd_t                    cmd_i,
  output dp_status_t                   status_o,
  input  logic [1:0]                   in_cmd_i,
  input  logic [15:0]                  in_addr_i,
  input  logic [7:0]                   in_data_i,
  output logic                         ram_we_o,
  output logic [$clog2(MEM_DEPTH)-1:0] ram_addr_o,
  output logic [7:0]                   ram_wdata_o,
  input  logic [7:0]                   ram_rdata_i,
  output logic [71:0]                  result_o
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [AW-1:0] clr_cnt_q;
  logic [1:0]    pull_cnt_q;
  logic [1:0]    cmd_q;
  logic [15:0]   addr_q;
  logic [7:0]    data_q;
  logic [7:0]    rbyte_q;
  logic [7:0]    op_q, b1_q, b2_q, plo_q, phi_q, m_q, t0_q, t1_q, t2_q;
  logic [7:0]    a_q, x_q, y_q, sp_q, p_q;
  logic [15:0]   pc_q;
  logic [71:0]   result_q;

  logic [1:0]  cc;
  logic [2:0]  bbb, aaa;
  logic [15:0] absv, ea, ptr_lo, ptr_hi, ret;
  logic [1:0]  len;
  logic        yidx;
  logic [7:0]  idx, zpx, zpi;

  logic [7:0]  a_n, x_n, y_n, sp_n, p_n;
  logic [15:0] pc_n;
  logic        we_x;
  logic [7:0]  wd_x;
  logic [15:0] wa_x;

  logic [15:0] ram_addr16;

  assign cc     = op_q[1:0];
  assign bbb    = op_q[4:2];
  assign aaa    = op_q[7:5];
  assign absv   = {b2_q, b1_q};
  assign yidx   = (cc == 2'd2) && (aaa == 3'd4 || aaa == 3'd5);
  assign idx    = yidx ? y_q : x_q;
  assign zpx    = b1_q + x_q;
  assign zpi    = b1_q + idx;
  assign ret    = pc_q + 16'd2;

  always_comb begin
    if (op_q == OP_JMP_IND) begin
      ptr_lo = absv;
      ptr_hi = {b2_q, b1_q + 8'd1};
    end else if (bbb == 3'd0) begin
      ptr_lo = {8'h00, zpx};
      ptr_hi = {8'h00, zpx + 8'd1};
    end else begin
      ptr_lo = {8'h00, b1_q};
      ptr_hi = {8'h00, b1_q + 8'd1};
    end
  end

  always_comb begin
    ea  = 16'h0000;
    len = 2'd2;
    if (cc == 2'd1) begin
      case (bbb)
        3'd0: ea = {phi_q, plo_q};
        3'd1: ea = {8'h00, b1_q};
        3'd2: ea = pc_q + 16'd1;
        3'd3: begin ea = absv; len = 2'd3; end
        3'd4: ea = {phi_q, plo_q} + {8'h00, y_q};
        3'd5: ea = {8'h00, zpx};
        3'd6: begin ea = absv + {8'h00, y_q}; len = 2'd3; end
        default: begin ea = absv + {8'h00, x_q}; len = 2'd3; end
      endcase
    end else begin
      case (bbb)
        3'd0: ea = pc_q + 16'd1;
        3'd1: ea = {8'h00, b1_q};
        3'd3: begin ea = absv; len = 2'd3; end
        3'd4: ea = 16'h0000;
        3'd5: ea = {8'h00, zpi};
        3'd7: begin ea = absv + {8'h00, idx}; len = 2'd3; end
        default: begin ea = 16'h0000; len = 2'd1; end
      endcase
    end
  end

  always_comb begin
    logic [8:0] sum;
    logic [7:0] opnd, r, src, sh;
    logic       f;
    a_n  = a_q;
    x_n  = x_q;
    y_n  = y_q;
    sp_n = sp_q;
    p_n  = p_q;
    pc_n = pc_q + {14'd0, len};
    we_x = 1'b0;
    wd_x = 8'h00;
    wa_x = ea;
    sum  = 9'd0;
    opnd = 8'h00;
    r    = 8'h00;
    src  = 8'h00;
    sh   = 8'h00;
    f    = 1'b0;
    unique case (op_q)
      OP_JSR: begin
        pc_n = pc_q;
        we_x = 1'b1;
        wa_x = {STACK_PAGE, sp_q};
        wd_x = ret[15:8];
        sp_n = sp_q - 8'd1;
      end
      OP_RTI, OP_RTS, OP_PLA, OP_PLP: pc_n = pc_q;
      OP_JMP:     pc_n = absv;
      OP_JMP_IND: pc_n = {phi_q, plo_q};
      OP_PHP: begin
        we_x = 1'b1;
        wa_x = {STACK_PAGE, sp_q};
        wd_x = p_q | 8'h30;
        sp_n = sp_q - 8'd1;
      end
      OP_PHA: begin
        we_x = 1'b1;
        wa_x = {STACK_PAGE, sp_q};
        wd_x = a_q;
        sp_n = sp_q - 8'd1;
      end
      OP_DEY: begin y_n = y_q - 8'd1; p_n = set_nz(p_q, y_n); end
      OP_INY: begin y_n = y_q + 8'd1; p_n = set_nz(p_q, y_n); end
      OP_DEX: begin x_n = x_q - 8'd1; p_n = set_nz(p_q, x_n); end
      OP_INX: begin x_n = x_q + 8'd1; p_n = set_nz(p_q, x_n); end
      OP_TAY: begin y_n = a_q; p_n = set_nz(p_q, a_q); end
      OP_TAX: begin x_n = a_q; p_n = set_nz(p_q, a_q); end
      OP_TYA: begin a_n = y_q; p_n = set_nz(p_q, y_q); end
      OP_TXA: begin a_n = x_q; p_n = set_nz(p_q, x_q); end
      OP_TSX: begin x_n = sp_q; p_n = set_nz(p_q, sp_q); end
      OP_TXS: sp_n = x_q;
      OP_CLC: p_n[FLAG_C] = 1'b0;
      OP_SEC: p_n[FLAG_C] = 1'b1;
      OP_CLI: p_n[FLAG_I] = 1'b0;
      OP_SEI: p_n[FLAG_I] = 1'b1;
      OP_CLV: p_n[FLAG_V] = 1'b0;
      OP_CLD: p_n[FLAG_D] = 1'b0;
      OP_SED: p_n[FLAG_D] = 1'b1;
      OP_NOP: pc_n = pc_q + 16'd1;
      OP_STA_IMM: pc_n = pc_q + 16'd1;
      default: begin
        case (cc)
          2'd1: begin
            case (aaa)
              3'd0: begin a_n = a_q | m_q; p_n = set_nz(p_q, a_n); end
              3'd1: begin a_n = a_q & m_q; p_n = set_nz(p_q, a_n); end
              3'd2: begin a_n = a_q ^ m_q; p_n = set_nz(p_q, a_n); end
              3'd4: begin we_x = 1'b1; wd_x = a_q; end
              3'd5: begin a_n = m_q; p_n = set_nz(p_q, m_q); end
              3'd6: begin
                r = a_q - m_q;
                p_n = set_nz(p_q, r);
                p_n[FLAG_C] = (a_q >= m_q);
              end
              default: begin
                opnd = (aaa == 3'd7) ? ~m_q : m_q;
                sum  = {1'b0, a_q} + {1'b0, opnd} + {8'd0, p_q[FLAG_C]};
                a_n  = sum[7:0];
                p_n  = set_nz(p_q, sum[7:0]);
                p_n[FLAG_C] = sum[8];
                p_n[FLAG_V] = (~(a_q[7] ^ opnd[7])) & (a_q[7] ^ sum[7]);
              end
            endcase
          end
          2'd2: begin
            if (aaa[2] == 1'b0) begin
              if (bbb == 3'd1 || bbb == 3'd2 || bbb == 3'd3 || bbb == 3'd5 ||
                  bbb == 3'd7) begin
                src = (bbb == 3'd2) ? a_q : m_q;
                if (aaa[1] == 1'b0) begin
                  sh = {src[6:0], aaa[0] & p_q[FLAG_C]};
                  p_n[FLAG_C] = src[7];
                end else begin
                  sh = {aaa[0] & p_q[FLAG_C], src[7:1]};
                  p_n[FLAG_C] = src[0];
                end
                p_n = set_nz(p_n, sh);
                if (bbb == 3'd2) begin
                  a_n = sh;
                end else begin
                  we_x = 1'b1;
                  wd_x = sh;
                end
              end else begin
                pc_n = pc_q + 16'd1;
              end
            end else if (aaa == 3'd4) begin
              if (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) begin
                we_x = 1'b1;
                wd_x = x_q;
              end else begin
                pc_n = pc_q + 16'd1;
              end
            end else if (aaa == 3'd5) begin
              if (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5 ||
                  bbb == 3'd7) begin
                x_n = m_q;
                p_n = set_nz(p_q, m_q);
              end else begin
                pc_n = pc_q + 16'd1;
              end
            end else begin
              if (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5 || bbb == 3'd7) begin
                r = (aaa == 3'd6) ? (m_q - 8'd1) : (m_q + 8'd1);
                p_n = set_nz(p_q, r);
                we_x = 1'b1;
                wd_x = r;
              end else begin
                pc_n = pc_q + 16'd1;
              end
            end
          end
          2'd0: begin
            if (bbb == 3'd4) begin
              case (aaa[2:1])
                2'd0: f = p_q[FLAG_N];
                2'd1: f = p_q[FLAG_V];
                2'd2: f = p_q[FLAG_C];
                default: f = p_q[FLAG_Z];
              endcase
              if (f == aaa[0]) begin
                pc_n = pc_q + 16'd2 + {{8{b1_q[7]}}, b1_q};
              end
            end else if (aaa == 3'd1 && (bbb == 3'd1 || bbb == 3'd3)) begin
              p_n[FLAG_Z] = ((a_q & m_q) == 8'h00);
              p_n[FLAG_V] = m_q[6];
              p_n[FLAG_N] = m_q[7];
            end else if (aaa == 3'd4 && (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5)) begin
              we_x = 1'b1;
              wd_x = y_q;
            end else if (aaa == 3'd5 && (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3 ||
                                         bbb == 3'd5 || bbb == 3'd7)) begin
              y_n = m_q;
              p_n = set_nz(p_q, m_q);
            end else if (aaa[2:1] == 2'b11 && (bbb == 3'd0 || bbb == 3'd1 ||
                                               bbb == 3'd3)) begin
              src = aaa[0] ? x_q : y_q;
              r = src - m_q;
              p_n = set_nz(p_q, r);
              p_n[FLAG_C] = (src >= m_q);
            end else begin
              pc_n = pc_q + 16'd1;
            end
          end
          default: pc_n = pc_q + 16'd1;
        endcase
      end
    endcase
  end

  always_comb begin
    ram_we_o    = 1'b0;
    ram_addr16  = 16'h0000;
    ram_wdata_o = 8'h00;
    ram_addr_o  = ram_addr16[AW-1:0];
    unique case (cmd_i.uop)
      UOP_CLEAR: begin
        ram_we_o   = 1'b1;
        ram_addr_o = clr_cnt_q;
      end
      UOP_MWRITE: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = addr_q[AW-1:0];
        ram_wdata_o = data_q;
      end
      UOP_MRD_ISSUE: ram_addr_o = addr_q[AW-1:0];
      UOP_RST_LO:    ram_addr_o = RST_VEC_LO[AW-1:0];
      UOP_RST_HI:    ram_addr_o = RST_VEC_HI[AW-1:0];
      UOP_F_OP:      ram_addr_o = pc_q[AW-1:0];
      UOP_F_B1: begin
        ram_addr16 = pc_q + 16'd1;
        ram_addr_o = ram_addr16[AW-1:0];
      end
      UOP_F_B2: begin
        ram_addr16 = pc_q + 16'd2;
        ram_addr_o = ram_addr16[AW-1:0];
      end
      UOP_P_LO:      ram_addr_o = ptr_lo[AW-1:0];
      UOP_P_HI:      ram_addr_o = ptr_hi[AW-1:0];
      UOP_M_ISSUE:   ram_addr_o = ea[AW-1:0];
      UOP_EXEC: begin
        ram_we_o    = we_x;
        ram_addr_o  = wa_x[AW-1:0];
        ram_wdata_o = wd_x;
      end
      UOP_PUSH_LO: begin
        ram_we_o    = 1'b1;
        ram_addr16  = {STACK_PAGE, sp_q};
        ram_addr_o  = ram_addr16[AW-1:0];
        ram_wdata_o = ret[7:0];
      end
      UOP_PULL_ISSUE: begin
        ram_addr16 = {STACK_PAGE, sp_q + 8'd1};
        ram_addr_o = ram_addr16[AW-1:0];
      end
      default: ram_addr_o = ram_addr16[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      pull_cnt_q <= 2'd0;
      a_q        <= 8'h00;
      x_q        <= 8'h00;
      y_q        <= 8'h00;
      sp_q       <= SP_RESET;
      p_q        <= P_RESET;
      pc_q       <= 16'h0000;
    end else begin
      unique case (cmd_i.uop)
        UOP_CLEAR: clr_cnt_q <= clr_cnt_q + 1'b1;
        UOP_RST_END: begin
          a_q  <= 8'h00;
          x_q  <= 8'h00;
          y_q  <= 8'h00;
          sp_q <= SP_RESET;
          p_q  <= P_RESET;
          pc_q <= {ram_rdata_i, b1_q};
        end
        UOP_F_OP: pull_cnt_q <= 2'd0;
        UOP_EXEC: begin
          a_q  <= a_n;
          x_q  <= x_n;
          y_q  <= y_n;
          sp_q <= sp_n;
          p_q  <= p_n;
          pc_q <= pc_n;
        end
        UOP_PUSH_LO: begin
          sp_q <= sp_q - 8'd1;
          pc_q <= absv;
        end
        UOP_PULL_ISSUE: begin
          sp_q       <= sp_q + 8'd1;
          pull_cnt_q <= pull_cnt_q + 2'd1;
        end
        UOP_STK_END: begin
          unique case (op_q)
            OP_PLA: begin
              a_q  <= t0_q;
              p_q  <= set_nz(p_q, t0_q);
              pc_q <= pc_q + 16'd1;
            end
            OP_PLP: begin
              p_q  <= (t0_q & ~8'h10) | 8'h20;
              pc_q <= pc_q + 16'd1;
            end
            OP_RTS: pc_q <= {t1_q, t0_q} + 16'd1;
            default: begin
              p_q  <= (t0_q & ~8'h10) | 8'h20;
              pc_q <= {t2_q, t1_q};
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.uop)
      UOP_ACCEPT: begin
        cmd_q  <= in_cmd_i;
        addr_q <= in_addr_i;
        data_q <= in_data_i;
      end
      UOP_MRD_LATCH:  rbyte_q <= ram_rdata_i;
      UOP_RST_HI:     b1_q    <= ram_rdata_i;
      UOP_F_B1:       op_q    <= ram_rdata_i;
      UOP_F_B2:       b1_q    <= ram_rdata_i;
      UOP_F_B2L:      b2_q    <= ram_rdata_i;
      UOP_P_HI:       plo_q   <= ram_rdata_i;
      UOP_P_END:      phi_q   <= ram_rdata_i;
      UOP_M_LATCH:    m_q     <= ram_rdata_i;
      UOP_PULL_LATCH: begin
        case (pull_cnt_q)
          2'd1:    t0_q <= ram_rdata_i;
          2'd2:    t1_q <= ram_rdata_i;
          default: t2_q <= ram_rdata_i;
        endcase
      end
      UOP_DONE: begin
        result_q <= {(cmd_q == CMD_EXEC) ? op_q : 8'h00, p_q, sp_q, y_q, x_q, a_q, pc_q,
                     (cmd_q == CMD_READ) ? rbyte_q : 8'h00};
      end
      default: begin
      end
    endcase
  end

  assign result_o            = result_q;
  assign status_o.clear_done = (clr_cnt_q == AW'(MEM_DEPTH - 1));
  assign status_o.need_ptr   = ((cc == 2'd1) && (bbb == 3'd0 || bbb == 3'd4)) ||
                               (op_q == OP_JMP_IND);
  assign status_o.opc        = op_class(op_q);
  assign status_o.pull_last  = (pull_cnt_q == pull_count(op_q));

endmodule

[src/c6502_ctrl.sv]
// Controller state machine that sequences memory accesses and execution steps.
module c6502_ctrl import c6502_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fire_done;

  assign fire_done = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(in_cmd_i))
            CMD_WRITE: state_d = ST_MWRITE;
            CMD_READ:  state_d = ST_MRD_ISSUE;
            CMD_RESET: state_d = ST_RST_LO;
            default:   state_d = ST_F_OP;
          endcase
        end
      end
      ST_MWRITE:     state_d = ST_DONE;
      ST_MRD_ISSUE:  state_d = ST_MRD_LATCH;
      ST_MRD_LATCH:  state_d = ST_DONE;
      ST_RST_LO:     state_d = ST_RST_HI;
      ST_RST_HI:     state_d = ST_RST_END;
      ST_RST_END:    state_d = ST_DONE;
      ST_F_OP:       state_d = ST_F_B1;
      ST_F_B1:       state_d = ST_F_B2;
      ST_F_B2:       state_d = ST_F_B2L;
      ST_F_B2L:      state_d = status_i.need_ptr ? ST_P_LO : ST_M_ISSUE;
      ST_P_LO:       state_d = ST_P_HI;
      ST_P_HI:       state_d = ST_P_END;
      ST_P_END:      state_d = ST_M_ISSUE;
      ST_M_ISSUE:    state_d = ST_M_LATCH;
      ST_M_LATCH:    state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (status_i.opc)
          OPC_JSR:  state_d = ST_PUSH_LO;
          OPC_PULL: state_d = ST_PULL_ISSUE;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_PUSH_LO:    state_d = ST_DONE;
      ST_PULL_ISSUE: state_d = ST_PULL_LATCH;
      ST_PULL_LATCH: state_d = status_i.pull_last ? ST_STK_END : ST_PULL_ISSUE;
      ST_STK_END:    state_d = ST_DONE;
      ST_DONE:       if (fire_done) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.uop  = UOP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.uop = UOP_CLEAR;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.uop = UOP_ACCEPT;
      end
      ST_MWRITE:     cmd_o.uop = UOP_MWRITE;
      ST_MRD_ISSUE:  cmd_o.uop = UOP_MRD_ISSUE;
      ST_MRD_LATCH:  cmd_o.uop = UOP_MRD_LATCH;
      ST_RST_LO:     cmd_o.uop = UOP_RST_LO;
      ST_RST_HI:     cmd_o.uop = UOP_RST_HI;
      ST_RST_END:    cmd_o.uop = UOP_RST_END;
      ST_F_OP:       cmd_o.uop = UOP_F_OP;
      ST_F_B1:       cmd_o.uop = UOP_F_B1;
      ST_F_B2:       cmd_o.uop = UOP_F_B2;
      ST_F_B2L:      cmd_o.uop = UOP_F_B2L;
      ST_P_LO:       cmd_o.uop = UOP_P_LO;
      ST_P_HI:       cmd_o.uop = UOP_P_HI;
      ST_P_END:      cmd_o.uop = UOP_P_END;
      ST_M_ISSUE:    cmd_o.uop = UOP_M_ISSUE;
      ST_M_LATCH:    cmd_o.uop = UOP_M_LATCH;
      ST_EXEC:       cmd_o.uop = UOP_EXEC;
      ST_PUSH_LO:    cmd_o.uop = UOP_PUSH_LO;
      ST_PULL_ISSUE: cmd_o.uop = UOP_PULL_ISSUE;
      ST_PULL_LATCH: cmd_o.uop = UOP_PULL_LATCH;
      ST_STK_END:    cmd_o.uop = UOP_STK_END;
      ST_DONE:       if (fire_done) cmd_o.uop = UOP_DONE;
      default:       cmd_o.uop = UOP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (fire_done) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/cpu6502_instruction_core_top.sv]
// Top level of the binary-only 6502 instruction core with its memory inside.
// After reset the core clears all MEM_DEPTH (65536) bytes of its memory, one a cycle,
// and accepts no item until that pass is done. Each item then steps through states on
// the single memory port up to loading the result register: a write state for a write,
// issue and latch for a read, vector reads for a core reset, and fetch, operand read and
// execute for an instruction, plus pointer reads for indirect modes, a push for JSR and
// an issue and latch per pulled byte. A result waits in an output register while the next
// item is accepted; the following result stalls until that register has been taken.
module cpu6502_instruction_core_top import c6502_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // mem_addr[15:0], mem_data[23:16]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // read_byte, prog_counter, accum, index_x, index_y,
                                     // stack_ptr, flags, last_opcode
);

  localparam int AW = $clog2(MEM_DEPTH);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  c6502_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  c6502_datapath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_cmd_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[15:0]),
    .in_data_i   (s_axis_tdata[23:16]),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .result_o    (m_axis_tdata)
  );

  c6502_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
